// ===== hdl/kpi_pkg.sv =====
// ----------------------------------------------------------------------------
// kpi_pkg: shared types for the keyframe pose interpolator
// Payload structs, controller/datapath command and status groups,
// fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package kpi_pkg;

  localparam int POS_W  = 32;   // Q16.16 position width
  localparam int ROT_W  = 16;   // Q2.14 quaternion component width
  localparam int FIDX_W = 6;    // frame index / span width
  localparam int DIV_W  = 64;   // shared divider width
  localparam int B_W    = 23;   // blended component width, signed

  typedef struct packed {
    logic                    req_type;
    logic [FIDX_W-1:0]       span_frames;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [ROT_W-1:0] rot_w;
    logic signed [ROT_W-1:0] rot_x;
    logic signed [ROT_W-1:0] rot_y;
    logic signed [ROT_W-1:0] rot_z;
  } kpi_in_t;

  typedef struct packed {
    logic [FIDX_W-1:0]       frame_index;
    logic signed [POS_W-1:0] out_x;
    logic signed [POS_W-1:0] out_y;
    logic signed [POS_W-1:0] out_z;
    logic signed [ROT_W-1:0] out_w;
    logic signed [ROT_W-1:0] out_qx;
    logic signed [ROT_W-1:0] out_qy;
    logic signed [ROT_W-1:0] out_qz;
    logic                    last;
  } kpi_out_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load_start;
    logic       load_end;
    logic       b_calc;
    logic       sq_acc;
    logic [1:0] comp_idx;
    logic       norm_step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_load;
    logic       div_step;
    logic       div_store;
    logic [2:0] div_idx;
    logic       out_load;
    logic       next_frame;
  } kpi_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic acc_zero;
    logic acc_norm;
    logic last;
  } kpi_sts_t;

endpackage

`default_nettype wire

// ===== hdl/keyframe_pose_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// keyframe_pose_interpolator_core: keyframe pose interpolation
// Position lerp and normalized quaternion blend between two key poses.
// ----------------------------------------------------------------------------
// Usage:
//   Input items go on in_valid/in_stall/in_data. An item with req_type 0
//   stores the start pose and produces nothing. An item with
//   req_type 1 stores the end pose and span n, then produces n+1 frame
//   items on out_valid/out_stall/out_data, frame_index 0..n, last set on
//   the final one. A span of zero produces a single frame of the start pose.
//   Each frame runs through blend and square sum, a zero test plus
//   normalize shifts, the square root (shifts and root skipped on a zero
//   blend), seven divisions (load, steps, store) on the one shared divider
//   (three positions, four quaternion components) and the frame hand-over.
//   in_stall stays high for the whole run.
//   Frames pass through an output register; while out_stall holds a frame,
//   the next one finishes and waits, and the next input item is taken as
//   soon as the last frame sits in that register.
//   Reset (rst_n low, synchronous) clears both key poses to zero and
//   empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_pose_interpolator_core #(
  parameter int MAX_SPAN      = 63,
  parameter int ROT_FRAC_BITS = 14
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire kpi_pkg::kpi_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output kpi_pkg::kpi_out_t     out_data
);

  kpi_pkg::kpi_cmd_t cmd;
  kpi_pkg::kpi_sts_t sts;

  // frame sequencer
  kpi_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .sts         (sts)
  );

  // arithmetic and storage
  kpi_dpath #(
    .MAX_SPAN      (MAX_SPAN),
    .ROT_FRAC_BITS (ROT_FRAC_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== hdl/kpi_ctrl.sv =====
// ----------------------------------------------------------------------------
// kpi_ctrl: frame sequencer
// Walks each frame through blend, square-sum, normalize, square root and
// seven shared divisions, then hands the frame to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kpi_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_req_type,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output kpi_pkg::kpi_cmd_t      cmd,
  input  wire kpi_pkg::kpi_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE, S_BCALC, S_SQ, S_NORM, S_SQRT, S_DLOAD, S_DSTEP, S_DSTORE, S_EMIT
  } state_t;

  localparam logic [5:0] SqrtLast = 6'd30;
  localparam logic [5:0] DivLast  = 6'(kpi_pkg::DIV_W - 1);
  localparam logic [2:0] KLast    = 3'd6;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [2:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.comp_idx  = cnt_r[1:0];
    cmd.div_idx   = k_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req_type) begin
            cmd.load_end = 1'b1;
            cnt_nxt      = '0;
            state_nxt    = S_BCALC;
          end else begin
            cmd.load_start = 1'b1;
          end
        end
      end
      S_BCALC: begin
        cmd.b_calc = 1'b1;
        cnt_nxt    = cnt_r + 6'd1;
        if (cnt_r[1:0] == 2'd3) begin
          cnt_nxt   = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq_acc = 1'b1;
        cnt_nxt    = cnt_r + 6'd1;
        if (cnt_r[1:0] == 2'd3) begin
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (sts.acc_zero) begin
          k_nxt     = '0;
          state_nxt = S_DLOAD;
        end else if (sts.acc_norm) begin
          cmd.sqrt_init = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = S_SQRT;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 6'd1;
        if (cnt_r == SqrtLast) begin
          k_nxt     = '0;
          state_nxt = S_DLOAD;
        end
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == DivLast) begin
          state_nxt = S_DSTORE;
        end
      end
      S_DSTORE: begin
        cmd.div_store = 1'b1;
        k_nxt         = k_r + 3'd1;
        state_nxt     = (k_r == KLast) ? S_EMIT : S_DLOAD;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          cnt_nxt       = '0;
          if (sts.last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.next_frame = 1'b1;
            state_nxt      = S_BCALC;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/kpi_dpath.sv =====
// ----------------------------------------------------------------------------
// kpi_dpath: interpolation datapath
// Key storage, quaternion blend and square-sum, normalize shifter,
// bit-pair square root, one shared restoring divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kpi_dpath #(
  parameter int MAX_SPAN      = 63,
  parameter int ROT_FRAC_BITS = 14
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire kpi_pkg::kpi_in_t  in_data,
  input  wire kpi_pkg::kpi_cmd_t cmd,
  output kpi_pkg::kpi_sts_t      sts,
  output kpi_pkg::kpi_out_t      out_data
);

  localparam int PW  = kpi_pkg::POS_W;
  localparam int RW  = kpi_pkg::ROT_W;
  localparam int FW  = kpi_pkg::FIDX_W;
  localparam int DW  = kpi_pkg::DIV_W;
  localparam int BW  = kpi_pkg::B_W;
  localparam int PRW = PW + 8;  // signed product of difference and index
  localparam logic [FW-1:0] MaxSpanW = FW'(MAX_SPAN);
  localparam logic [DW-1:0] NormLim  = DW'(1) << 60;
  localparam logic [DW-1:0] RotCap   = DW'(1) << ROT_FRAC_BITS;

  // key storage
  logic signed [PW-1:0] s_pos_r [3];
  logic signed [PW-1:0] e_pos_r [3];
  logic signed [RW-1:0] s_rot_r [4];
  logic signed [RW-1:0] e_rot_r [4];
  logic [FW-1:0]        n_r, eff_r, i_r;

  // frame working registers
  logic signed [BW-1:0] b_r [4];
  logic [DW-1:0]        acc_r;
  logic [5:0]           sh_r;
  logic [DW-1:0]        sx_r, sres_r, sbit_r;
  logic [DW:0]          rem_r;
  logic [DW-1:0]        quo_r, den_r;
  logic                 neg_r;
  logic signed [PW-1:0] pos_res_r [3];
  logic signed [RW-1:0] rot_res_r [4];
  kpi_pkg::kpi_out_t    out_r;

  // span saturation
  logic [FW-1:0] span_sat;
  assign span_sat = (in_data.span_frames > MaxSpanW) ? MaxSpanW : in_data.span_frames;

  // blend of one component: s*(eff-i) + e*i, eff being n, or 1 for a zero span
  logic [FW-1:0]        w0;
  logic signed [BW-1:0] sx_b, ex_b, w0_b, w1_b, b_calc;
  always_comb begin
    w0     = eff_r - i_r;
    sx_b   = {{(BW-RW){s_rot_r[cmd.comp_idx][RW-1]}}, s_rot_r[cmd.comp_idx]};
    ex_b   = {{(BW-RW){e_rot_r[cmd.comp_idx][RW-1]}}, e_rot_r[cmd.comp_idx]};
    w0_b   = {{(BW-FW){1'b0}}, w0};
    w1_b   = {{(BW-FW){1'b0}}, i_r};
    b_calc = sx_b * w0_b + ex_b * w1_b;
  end

  // square of one blended component
  logic [BW-2:0]       bmag_sq;
  logic [2*BW-3:0]     sq;
  logic signed [BW-1:0] b_sel;
  always_comb begin
    b_sel   = b_r[cmd.comp_idx];
    bmag_sq = b_sel[BW-1] ? (BW-1)'(-b_sel) : b_sel[BW-2:0];
    sq      = {{(BW-1){1'b0}}, bmag_sq} * {{(BW-1){1'b0}}, bmag_sq};
  end

  // square root step
  logic [DW-1:0] s_trial;
  assign s_trial = sres_r + sbit_r;

  // divider step
  logic [DW:0] d_t;
  logic        d_ge;
  assign d_t  = {rem_r[DW-1:0], quo_r[DW-1]};
  assign d_ge = d_t >= {1'b0, den_r};

  // divider operands
  logic [1:0]            pk, rk;
  logic signed [PW:0]    diff;
  logic signed [PRW-1:0] prod;
  logic [PRW-1:0]        pmag;
  logic signed [BW-1:0]  b_div;
  logic [BW-2:0]         bmag_dv;
  logic [6:0]            shamt;
  logic [DW-1:0]         rshift;
  always_comb begin
    pk      = cmd.div_idx[1:0];
    rk      = 2'(cmd.div_idx - 3'd3);
    diff    = {e_pos_r[pk][PW-1], e_pos_r[pk]} - {s_pos_r[pk][PW-1], s_pos_r[pk]};
    prod    = {{(PRW-PW-1){diff[PW]}}, diff} * $signed({{(PRW-FW){1'b0}}, i_r});
    pmag    = prod[PRW-1] ? PRW'(-prod) : prod;
    b_div   = b_r[rk];
    bmag_dv = b_div[BW-1] ? (BW-1)'(-b_div) : b_div[BW-2:0];
    shamt   = 7'(ROT_FRAC_BITS) + {2'b0, sh_r[5:1]};
    rshift  = DW'(bmag_dv) << shamt;
  end

  // divider result
  logic [DW-1:0] q_cap, q_rot;
  always_comb begin
    q_cap = (quo_r > RotCap) ? RotCap : quo_r;
    q_rot = neg_r ? DW'(-q_cap) : q_cap;
  end

  // key and frame registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < 3; l++) begin
        s_pos_r[l] <= '0;
        e_pos_r[l] <= '0;
      end
      for (int l = 0; l < 4; l++) begin
        s_rot_r[l] <= '0;
        e_rot_r[l] <= '0;
      end
      n_r   <= '0;
      eff_r <= FW'(1);
      i_r   <= '0;
    end else begin
      if (cmd.load_start) begin
        s_pos_r[0] <= in_data.pos_x;
        s_pos_r[1] <= in_data.pos_y;
        s_pos_r[2] <= in_data.pos_z;
        s_rot_r[0] <= in_data.rot_w;
        s_rot_r[1] <= in_data.rot_x;
        s_rot_r[2] <= in_data.rot_y;
        s_rot_r[3] <= in_data.rot_z;
      end
      if (cmd.load_end) begin
        e_pos_r[0] <= in_data.pos_x;
        e_pos_r[1] <= in_data.pos_y;
        e_pos_r[2] <= in_data.pos_z;
        e_rot_r[0] <= in_data.rot_w;
        e_rot_r[1] <= in_data.rot_x;
        e_rot_r[2] <= in_data.rot_y;
        e_rot_r[3] <= in_data.rot_z;
        n_r        <= span_sat;
        eff_r      <= (span_sat == '0) ? FW'(1) : span_sat;
        i_r        <= '0;
      end
      if (cmd.next_frame) begin
        i_r <= i_r + FW'(1);
      end
    end
  end

  // arithmetic working registers
  always_ff @(posedge clk) begin
    if (cmd.b_calc) begin
      b_r[cmd.comp_idx] <= b_calc;
    end
    if (cmd.sq_acc) begin
      acc_r <= (cmd.comp_idx == 2'd0) ? DW'(sq) : acc_r + DW'(sq);
      sh_r  <= '0;
    end
    if (cmd.norm_step) begin
      acc_r <= acc_r << 2;
      sh_r  <= sh_r + 6'd2;
    end
    if (cmd.sqrt_init) begin
      sx_r   <= acc_r;
      sres_r <= '0;
      sbit_r <= NormLim;
    end
    if (cmd.sqrt_step) begin
      if (sx_r >= s_trial) begin
        sx_r   <= sx_r - s_trial;
        sres_r <= (sres_r >> 1) + sbit_r;
      end else begin
        sres_r <= sres_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
    end
    if (cmd.div_load) begin
      rem_r <= '0;
      if (cmd.div_idx < 3'd3) begin
        quo_r <= DW'({pmag, 1'b0}) + DW'(eff_r);
        den_r <= DW'({eff_r, 1'b0});
        neg_r <= prod[PRW-1];
      end else begin
        quo_r <= (rshift << 1) + sres_r;
        den_r <= sres_r << 1;
        neg_r <= b_div[BW-1];
      end
    end
    if (cmd.div_step) begin
      rem_r <= d_ge ? (d_t - {1'b0, den_r}) : d_t;
      quo_r <= {quo_r[DW-2:0], d_ge};
    end
    if (cmd.div_store) begin
      if (cmd.div_idx < 3'd3) begin
        pos_res_r[pk] <= neg_r ? s_pos_r[pk] - quo_r[PW-1:0] : s_pos_r[pk] + quo_r[PW-1:0];
      end else begin
        rot_res_r[rk] <= (acc_r == '0) ? '0 : q_rot[RW-1:0];
      end
    end
    if (cmd.out_load) begin
      out_r.frame_index <= i_r;
      out_r.out_x       <= pos_res_r[0];
      out_r.out_y       <= pos_res_r[1];
      out_r.out_z       <= pos_res_r[2];
      out_r.out_w       <= rot_res_r[0];
      out_r.out_qx      <= rot_res_r[1];
      out_r.out_qy      <= rot_res_r[2];
      out_r.out_qz      <= rot_res_r[3];
      out_r.last        <= (i_r == n_r);
    end
  end

  assign sts.acc_zero = (acc_r == '0);
  assign sts.acc_norm = (acc_r >= NormLim);
  assign sts.last     = (i_r == n_r);
  assign out_data     = out_r;

endmodule

`default_nettype wire
